// ----- src/chained_hash_table_defines.svh -----
// Assertion macros used by the top file to check this block.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

`define CHT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `CHT_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CHT_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

// ----- src/cht_pkg.sv -----
`default_nettype none
package cht_pkg;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned KEY_W   = 20;
  localparam int unsigned PHONE_W = 34;
  localparam int unsigned NAME_W  = 64;
  localparam int unsigned TIME_W  = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned BIDX_W  = 4;
  localparam int unsigned TOTAL_W = 9;

  localparam int unsigned BUCKETS_DEF = 16;
  localparam int unsigned POOL_DEF    = 256;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BKT, S_HEAD, S_POP, S_WRITE,
    S_WALK, S_CMP, S_FREE, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_HASH, OP_FULL, OP_RECYCLE, OP_FRESH, OP_POP,
    OP_WRITE, OP_START, OP_WALK, OP_NEXT, OP_HIT, OP_UNLINK, OP_FREE, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic is_ins;
    logic is_del;
    logic full;
    logic recyc;
    logic head_nil;
    logic link_nil;
    logic key_match;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- src/chained_hash_table.sv -----
// Separate-chaining hash table with a node pool of POOL_ENTRIES entries and BUCKETS
// chains. One transaction is handled at a time. The bucket is the key modulo BUCKETS,
// found by a multiplication with the reciprocal of BUCKETS and a correction, then the
// chain is walked in node memory one node per cycle through a single registered read
// port. A search ends at its key or at the end of the chain, and a delete that finds
// its key also returns the node to the free list. An insert appends to the end of its
// chain, reusing a freed node when there is one; an insert into a full pool ends with
// a full status. A result still stalled in the output register holds the next one back
// in its final state, and the next transaction is accepted in the cycle after a result
// is loaded. After reset the block clears the bucket heads before it accepts its first
// transaction.
`default_nettype none
`include "chained_hash_table_defines.svh"
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS      = BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = POOL_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ACT_W-1:0]   action_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [PHONE_W-1:0] owner_phone_i,
  input  wire logic [NAME_W-1:0]  owner_name_i,
  input  wire logic [TIME_W-1:0]  check_in_seconds_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [KEY_W-1:0]        found_key_o,
  output logic [PHONE_W-1:0]      found_phone_o,
  output logic [NAME_W-1:0]       found_name_o,
  output logic [TIME_W-1:0]       found_time_o,
  output logic [BIDX_W-1:0]       bucket_index_o,
  output logic [TOTAL_W-1:0]      entry_total_o
);

  localparam logic [TOTAL_W-1:0] POOL_TOTAL = TOTAL_W'(POOL_ENTRIES);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_full;

  assign out_full = out_valid_o && (status_o == ST_FULL);

  cht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cht_datapath #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (action_i),
    .key_i              (key_i),
    .owner_phone_i      (owner_phone_i),
    .owner_name_i       (owner_name_i),
    .check_in_seconds_i (check_in_seconds_i),
    .status_o           (status_o),
    .found_key_o        (found_key_o),
    .found_phone_o      (found_phone_o),
    .found_name_o       (found_name_o),
    .found_time_o       (found_time_o),
    .bucket_index_o     (bucket_index_o),
    .entry_total_o      (entry_total_o)
  );

  `CHT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "idle after accept")
  `CHT_ASSERT_IMPL(a_status_code, out_valid_o, status_o <= ST_FULL, "bad status code")
  `CHT_ASSERT_IMPL(a_full_total, out_full, entry_total_o == POOL_TOTAL, "full below capacity")
  `CHT_ASSERT_IMPL(a_miss_key, out_valid_o && status_o == ST_MISS, found_key_o == '0, "miss key")

endmodule
`default_nettype wire

// ----- src/cht_ctrl.sv -----
`default_nettype none
module cht_ctrl
  import cht_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_HASH;
      S_HASH:  if (sts_i.hash_last) state_d = S_BKT;
      S_BKT:   state_d = S_HEAD;
      S_HEAD: begin
        if (sts_i.is_ins) begin
          if (sts_i.full) state_d = S_FIN;
          else if (sts_i.recyc) state_d = S_POP;
          else state_d = S_WRITE;
        end else begin
          state_d = sts_i.head_nil ? S_FIN : S_CMP;
        end
      end
      S_POP:   state_d = S_WRITE;
      S_WRITE: state_d = sts_i.head_nil ? S_FIN : S_WALK;
      S_WALK:  if (sts_i.link_nil) state_d = S_FIN;
      S_CMP: begin
        if (sts_i.key_match) state_d = sts_i.is_del ? S_FREE : S_FIN;
        else if (sts_i.link_nil) state_d = S_FIN;
      end
      S_FREE:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      S_HASH:  cmd_o.op = OP_HASH;
      S_BKT:   cmd_o.op = OP_NONE;
      S_HEAD: begin
        if (sts_i.is_ins) begin
          if (sts_i.full) cmd_o.op = OP_FULL;
          else if (sts_i.recyc) cmd_o.op = OP_RECYCLE;
          else cmd_o.op = OP_FRESH;
        end else if (!sts_i.head_nil) begin
          cmd_o.op = OP_START;
        end
      end
      S_POP:   cmd_o.op = OP_POP;
      S_WRITE: cmd_o.op = OP_WRITE;
      S_WALK:  cmd_o.op = OP_WALK;
      S_CMP: begin
        if (sts_i.key_match) cmd_o.op = sts_i.is_del ? OP_UNLINK : OP_HIT;
        else cmd_o.op = OP_NEXT;
      end
      S_FREE:  cmd_o.op = OP_FREE;
      S_FIN:   if (out_free) cmd_o.op = OP_OUT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.op == OP_OUT) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/cht_datapath.sv -----
`default_nettype none
module cht_datapath
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS      = BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = POOL_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  input  wire logic [ACT_W-1:0]   action_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [PHONE_W-1:0] owner_phone_i,
  input  wire logic [NAME_W-1:0]  owner_name_i,
  input  wire logic [TIME_W-1:0]  check_in_seconds_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [KEY_W-1:0]        found_key_o,
  output logic [PHONE_W-1:0]      found_phone_o,
  output logic [NAME_W-1:0]       found_name_o,
  output logic [TIME_W-1:0]       found_time_o,
  output logic [BIDX_W-1:0]       bucket_index_o,
  output logic [TOTAL_W-1:0]      entry_total_o
);

  localparam int unsigned BW   = $clog2(BUCKETS);
  localparam int unsigned PW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned IW   = $clog2(POOL_ENTRIES);
  localparam int unsigned SH   = KEY_W + BW;
  localparam int unsigned PRW  = SH + KEY_W;
  localparam int unsigned DW   = KEY_W + PHONE_W + NAME_W + TIME_W;
  localparam logic [PW-1:0]  NIL   = PW'(POOL_ENTRIES);
  localparam logic [PRW-1:0] MAGIC =
    PRW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  logic [DW-1:0] data_mem [POOL_ENTRIES];
  logic [PW-1:0] link_mem [POOL_ENTRIES];
  logic [PW-1:0] bkt_mem  [BUCKETS];

  logic [DW-1:0] data_rd_q;
  logic [PW-1:0] link_rd_q, bkt_rd_q;

  logic [ACT_W-1:0]   act_q;
  logic [KEY_W-1:0]   key_q, quo_q;
  logic [PHONE_W-1:0] phone_q, fphone_q;
  logic [NAME_W-1:0]  name_q, fname_q;
  logic [TIME_W-1:0]  time_q, ftime_q;
  logic [STAT_W-1:0]  st_q;
  logic               cnt_q;
  logic [BW-1:0]      rem_q, clr_q;
  logic [PW-1:0]      p_q, prev_q, n_q, free_q, fresh_q, count_q;

  logic [PRW-1:0] prod;
  logic [KEY_W-1:0] quo_d, rem_full;
  logic [PW-1:0]  rd_addr;
  logic           link_we, bkt_we;
  logic [PW-1:0]  link_wa, link_wd, bkt_wd;
  logic [BW-1:0]  bkt_wa;
  logic           head_nil, link_nil;
  logic [BW+BIDX_W-1:0]  bidx_ext;
  logic [PW+TOTAL_W-1:0] total_ext;

  assign head_nil = (bkt_rd_q == NIL);
  assign link_nil = (link_rd_q == NIL);

  // The quotient comes from a multiplication by the rounded-up reciprocal of BUCKETS,
  // which is exact for every key width value; the remainder follows in the next cycle.
  assign prod     = PRW'(key_q) * MAGIC;
  assign quo_d    = prod[SH +: KEY_W];
  assign rem_full = key_q - quo_q * KEY_W'(BUCKETS);

  always_comb begin
    sts_o.clr_last  = (clr_q == BW'(BUCKETS - 1));
    sts_o.hash_last = cnt_q;
    sts_o.is_ins    = (act_q == ACT_INSERT);
    sts_o.is_del    = (act_q == ACT_DELETE);
    sts_o.full      = (free_q == NIL) && (fresh_q == NIL);
    sts_o.recyc     = (free_q != NIL);
    sts_o.head_nil  = head_nil;
    sts_o.link_nil  = link_nil;
    sts_o.key_match = (data_rd_q[DW-1 -: KEY_W] == key_q);
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_RECYCLE:        rd_addr = free_q;
      OP_START, OP_WRITE: rd_addr = bkt_rd_q;
      OP_NEXT, OP_WALK:  rd_addr = link_rd_q;
      default:           rd_addr = p_q;
    endcase
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = p_q;
    link_wd = n_q;
    bkt_we  = 1'b0;
    bkt_wa  = rem_q;
    bkt_wd  = n_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        bkt_we = 1'b1;
        bkt_wa = clr_q;
        bkt_wd = NIL;
      end
      OP_WRITE: begin
        link_we = 1'b1;
        link_wa = n_q;
        link_wd = NIL;
        bkt_we  = head_nil;
      end
      OP_WALK: link_we = link_nil;
      OP_UNLINK: begin
        if (prev_q == NIL) begin
          bkt_we = 1'b1;
          bkt_wd = link_rd_q;
        end else begin
          link_we = 1'b1;
          link_wa = prev_q;
          link_wd = link_rd_q;
        end
      end
      OP_FREE: begin
        link_we = 1'b1;
        link_wd = free_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_rd_q <= bkt_mem[rem_q];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa[IW-1:0]] <= link_wd;
    link_rd_q <= link_mem[rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE) data_mem[n_q[IW-1:0]] <= {key_q, phone_q, name_q, time_q};
    data_rd_q <= data_mem[rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      cnt_q   <= 1'b0;
      free_q  <= NIL;
      fresh_q <= '0;
      count_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_CLEAR:  clr_q   <= clr_q + 1'b1;
        OP_LOAD:   cnt_q   <= 1'b0;
        OP_HASH:   cnt_q   <= 1'b1;
        OP_POP:    free_q  <= link_rd_q;
        OP_FRESH:  fresh_q <= fresh_q + 1'b1;
        OP_WRITE:  count_q <= count_q + 1'b1;
        OP_UNLINK: count_q <= count_q - 1'b1;
        OP_FREE:   free_q  <= p_q;
        default: ;
      endcase
    end
  end

  assign bidx_ext  = {{BIDX_W{1'b0}}, rem_q};
  assign total_ext = {{TOTAL_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        act_q    <= action_i;
        key_q    <= key_i;
        phone_q  <= owner_phone_i;
        name_q   <= owner_name_i;
        time_q   <= check_in_seconds_i;
        rem_q    <= '0;
        st_q     <= (action_i == ACT_INSERT) ? ST_OK : ST_MISS;
        fphone_q <= '0;
        fname_q  <= '0;
        ftime_q  <= '0;
      end
      OP_HASH: begin
        if (!cnt_q) quo_q <= quo_d;
        else rem_q <= rem_full[BW-1:0];
      end
      OP_FULL:    st_q <= ST_FULL;
      OP_RECYCLE: n_q  <= free_q;
      OP_FRESH:   n_q  <= fresh_q;
      OP_WRITE:   p_q  <= bkt_rd_q;
      OP_START: begin
        p_q    <= bkt_rd_q;
        prev_q <= NIL;
      end
      OP_WALK: if (!link_nil) p_q <= link_rd_q;
      OP_NEXT: begin
        prev_q <= p_q;
        p_q    <= link_rd_q;
      end
      OP_HIT: begin
        st_q     <= ST_OK;
        fphone_q <= data_rd_q[NAME_W+TIME_W +: PHONE_W];
        fname_q  <= data_rd_q[TIME_W +: NAME_W];
        ftime_q  <= data_rd_q[TIME_W-1:0];
      end
      OP_UNLINK: st_q <= ST_OK;
      OP_OUT: begin
        status_o       <= st_q;
        found_key_o    <= (st_q == ST_MISS) ? '0 : key_q;
        found_phone_o  <= fphone_q;
        found_name_o   <= fname_q;
        found_time_o   <= ftime_q;
        bucket_index_o <= bidx_ext[BIDX_W-1:0];
        entry_total_o  <= total_ext[TOTAL_W-1:0];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
